// File: rtl/lru_palette_slot_allocator_core_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef LRU_PALETTE_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define LRU_PALETTE_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define LPSA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LPSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lpsa_pkg.sv
package lpsa_pkg;

   localparam int NUM_SLOTS    = 256;
   localparam int COLOUR_SPACE = 32768;

   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int IDX_W     = $clog2(COLOUR_SPACE);
   localparam int COLOUR_W  = 15;
   localparam int COMP_W    = 5;
   localparam int RGB_W     = 8;
   localparam int AGE_W     = 16;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 8;
   localparam int OUT_SLOT_W = 8;

   localparam logic [CFG_W-1:0] SLOT_MIN = CFG_W'(1);
   localparam logic [CFG_W-1:0] SLOT_MAX = CFG_W'(NUM_SLOTS - 1);
   localparam logic [CFG_W-1:0] RESET_FIRST_SLOT = CFG_W'(1);
   localparam logic [CFG_W-1:0] RESET_LAST_SLOT  = CFG_W'(239);

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SLOT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_SLOT  = CSR_IDX_W'(1);

   localparam logic KIND_COLOUR = 1'b0;
   localparam logic KIND_FRAME  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_SCAN,
      ST_EVICT,
      ST_COMMIT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] colour;
      logic [AGE_W-1:0]    age;
   } slot_entry_type;

   function automatic logic [RGB_W-1:0] expand5(input logic [COMP_W-1:0] c);
      return {c, c[COMP_W-1:COMP_W-3]};
   endfunction

endpackage

// File: rtl/lpsa_if.sv
interface lpsa_req_if import lpsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [COLOUR_W-1:0] color;

   modport source (output valid, output kind, output color, input ready);
   modport sink (input valid, input kind, input color, output ready);
endinterface

interface lpsa_rsp_if import lpsa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OUT_SLOT_W-1:0] slot;
   logic                  loaded;
   logic [RGB_W-1:0]      red;
   logic [RGB_W-1:0]      green;
   logic [RGB_W-1:0]      blue;

   modport source (output valid, output slot, output loaded, output red, output green,
                   output blue, input ready);
   modport sink (input valid, input slot, input loaded, input red, input green,
                 input blue, output ready);
endinterface

interface lpsa_csr_if import lpsa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/lru_palette_slot_allocator_core.sv
// Palette slot allocator. Each colour item returns one item with the slot holding that
// colour; a frame item advances the frame stamp and returns nothing. The block handles
// one item at a time through a slot table (owner colour and age) read at one address a
// cycle. A hit passes LOOKUP and CHECK before its result is offered in OUTPUT; a miss
// also scans the slots from first_slot until the first free one or last_slot, passes
// EVICT when an owned slot is reused, and then COMMIT. The next item is taken once the
// block is back in IDLE after the result is taken. A frame item is taken in IDLE and
// leaves the block there. After reset all 32768 colour map entries are swept to zero,
// and no item is accepted during the sweep; configuration writes are taken at any time.
`include "lru_palette_slot_allocator_core_assert.svh"

module lru_palette_slot_allocator_core import lpsa_pkg::*; (
   input logic        clock,
   input logic        reset,
   lpsa_req_if.sink   req_if,
   lpsa_rsp_if.source rsp_if,
   lpsa_csr_if.sink   csr_if
);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]    first_slot_ff, first_slot_in;
   logic [CFG_W-1:0]    last_slot_ff, last_slot_in;
   logic [AGE_W-1:0]    stamp_ff, stamp_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [NUM_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [COLOUR_W-1:0] colour_ff, colour_in;
   logic [SLOT_W-1:0]   scan_ff, scan_in;
   logic [SLOT_W-1:0]   best_ff, best_in;
   logic [AGE_W-1:0]    best_age_ff, best_age_in;
   logic                have_ff, have_in;
   logic [SLOT_W-1:0]   chosen_ff, chosen_in;
   logic                loaded_ff, loaded_in;

   logic [SLOT_W-1:0]   c2s_mem [COLOUR_SPACE];
   logic [SLOT_W-1:0]   c2s_rd_ff;
   logic                c2s_we;
   logic [IDX_W-1:0]    c2s_waddr;
   logic [SLOT_W-1:0]   c2s_wdata;

   slot_entry_type      slot_mem [NUM_SLOTS];
   slot_entry_type      slot_rd_ff;
   logic [SLOT_W-1:0]   slot_raddr;
   logic                slot_we;
   logic [SLOT_W-1:0]   slot_waddr;
   slot_entry_type      slot_wdata;

   logic [CFG_W-1:0]    lo_cfg, hi_cfg;
   logic [SLOT_W-1:0]   lo, hi;
   logic                req_accept;
   logic                hit;
   logic                scan_free, scan_cand, scan_last, have_next;
   logic [SLOT_W-1:0]   best_next, pick;

   assign req_accept    = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign csr_if.ready  = 1'b1;

   assign rsp_if.valid  = (state_ff == ST_OUTPUT);
   assign rsp_if.slot   = OUT_SLOT_W'(chosen_ff);
   assign rsp_if.loaded = loaded_ff;
   assign rsp_if.red    = expand5(colour_ff[14:10]);
   assign rsp_if.green  = expand5(colour_ff[9:5]);
   assign rsp_if.blue   = expand5(colour_ff[4:0]);

   // clamp the configured range into the table
   always_comb begin
      lo_cfg = (first_slot_ff < SLOT_MIN) ? SLOT_MIN : first_slot_ff;
      if (lo_cfg > SLOT_MAX) begin
         lo_cfg = SLOT_MAX;
      end
      hi_cfg = (last_slot_ff < SLOT_MIN) ? SLOT_MIN : last_slot_ff;
      if (hi_cfg > SLOT_MAX) begin
         hi_cfg = SLOT_MAX;
      end
      if (hi_cfg < lo_cfg) begin
         hi_cfg = lo_cfg;
      end
      lo = SLOT_W'(lo_cfg);
      hi = SLOT_W'(hi_cfg);
   end

   always_comb begin
      hit = (chosen_ff >= lo) && (chosen_ff <= hi) && slot_valid_ff[chosen_ff]
            && (slot_rd_ff.colour == colour_ff);
      scan_free = !slot_valid_ff[scan_ff];
      scan_cand = (slot_rd_ff.age != stamp_ff) && (slot_rd_ff.age <= best_age_ff);
      best_next = scan_cand ? scan_ff : best_ff;
      have_next = have_ff || scan_cand;
      scan_last = (scan_ff == hi);
      pick      = have_next ? best_next : lo;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && (req_if.kind == KIND_COLOUR)) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_CHECK;
         ST_CHECK:  state_in = hit ? ST_OUTPUT : ST_SCAN;
         ST_SCAN: begin
            if (scan_free) begin
               state_in = ST_COMMIT;
            end else if (scan_last) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_OUTPUT;
         ST_OUTPUT: begin
            if (rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      first_slot_in = first_slot_ff;
      last_slot_in  = last_slot_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_FIRST_SLOT: first_slot_in = csr_if.data;
            CSR_LAST_SLOT:  last_slot_in  = csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      stamp_in      = stamp_ff;
      clr_in        = clr_ff;
      slot_valid_in = slot_valid_ff;
      colour_in     = colour_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_age_in   = best_age_ff;
      have_in       = have_ff;
      chosen_in     = chosen_ff;
      loaded_in     = loaded_ff;
      c2s_we        = 1'b0;
      c2s_waddr     = colour_ff[IDX_W-1:0];
      c2s_wdata     = chosen_ff;
      slot_we       = 1'b0;
      slot_waddr    = chosen_ff;
      slot_wdata    = '{colour: colour_ff, age: stamp_ff};
      slot_raddr    = chosen_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            c2s_we    = 1'b1;
            c2s_waddr = clr_ff;
            c2s_wdata = '0;
            clr_in    = IDX_W'(clr_ff + 1'b1);
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_if.kind == KIND_FRAME) begin
                  stamp_in = AGE_W'(stamp_ff + 1'b1);
               end else begin
                  colour_in = req_if.color;
               end
            end
         end
         ST_LOOKUP: begin
            slot_raddr = c2s_rd_ff;
            chosen_in  = c2s_rd_ff;
         end
         ST_CHECK: begin
            slot_raddr  = lo;
            scan_in     = lo;
            best_in     = lo;
            best_age_in = '1;
            have_in     = 1'b0;
            if (hit) begin
               slot_we   = 1'b1;
               loaded_in = 1'b0;
            end
         end
         ST_SCAN: begin
            best_in     = best_next;
            best_age_in = scan_cand ? slot_rd_ff.age : best_age_ff;
            have_in     = have_next;
            scan_in     = SLOT_W'(scan_ff + 1'b1);
            slot_raddr  = scan_last ? pick : SLOT_W'(scan_ff + 1'b1);
            if (scan_free) begin
               chosen_in = scan_ff;
            end else if (scan_last) begin
               chosen_in = pick;
            end
         end
         ST_EVICT: begin
            c2s_we    = 1'b1;
            c2s_waddr = slot_rd_ff.colour[IDX_W-1:0];
            c2s_wdata = '0;
         end
         ST_COMMIT: begin
            c2s_we                   = 1'b1;
            slot_we                  = 1'b1;
            slot_valid_in[chosen_ff] = 1'b1;
            loaded_in                = 1'b1;
         end
         ST_OUTPUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         first_slot_ff <= RESET_FIRST_SLOT;
         last_slot_ff  <= RESET_LAST_SLOT;
         stamp_ff      <= '0;
         clr_ff        <= '0;
         slot_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         first_slot_ff <= first_slot_in;
         last_slot_ff  <= last_slot_in;
         stamp_ff      <= stamp_in;
         clr_ff        <= clr_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      colour_ff   <= colour_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
      have_ff     <= have_in;
      chosen_ff   <= chosen_in;
      loaded_ff   <= loaded_in;
   end

   always_ff @(posedge clock) begin
      if (c2s_we) begin
         c2s_mem[c2s_waddr] <= c2s_wdata;
      end
      c2s_rd_ff <= c2s_mem[req_if.color[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[slot_raddr];
   end

   `LPSA_ASSERT_IMPLY(a_scan_in_range, clock, reset, state_ff == ST_SCAN,
      (scan_ff >= lo) && (scan_ff <= hi), "scan pointer left the slot range")
   `LPSA_ASSERT_IMPLY(a_commit_in_range, clock, reset, state_ff == ST_COMMIT,
      (chosen_ff >= lo) && (chosen_ff <= hi), "chosen slot outside the slot range")
   `LPSA_ASSERT_IMPLY(a_evict_owned, clock, reset, state_ff == ST_EVICT,
      slot_valid_ff[chosen_ff], "eviction of a free slot")
   `LPSA_ASSERT_IMPLY(a_rsp_slot_owned, clock, reset, rsp_if.valid,
      slot_valid_ff[chosen_ff] && (chosen_ff != '0), "result names an unowned slot")
   `LPSA_ASSERT_NEXT(a_frame_stamp, clock, reset,
      req_accept && (req_if.kind == KIND_FRAME),
      stamp_ff == AGE_W'($past(stamp_ff) + 1'b1), "frame item did not advance stamp")

endmodule

// File: dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lpsa_pkg::*;

   typedef struct {
      logic                kind;
      logic [COLOUR_W-1:0] color;
   } palette_req_type;

   typedef struct {
      logic [OUT_SLOT_W-1:0] slot;
      logic                  loaded;
      logic [RGB_W-1:0]      red;
      logic [RGB_W-1:0]      green;
      logic [RGB_W-1:0]      blue;
   } slot_grant_type;

   logic clock;
   logic reset;

   lpsa_req_if req_bus ();
   lpsa_rsp_if rsp_bus ();
   lpsa_csr_if csr_bus ();

   lru_palette_slot_allocator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   palette_req_type colour_items [$];
   slot_grant_type  due_grants [$];

   bit [SLOT_W-1:0]   colour_map [COLOUR_SPACE];
   bit                slot_live [NUM_SLOTS];
   bit [COLOUR_W-1:0] slot_colour [NUM_SLOTS];
   bit [AGE_W-1:0]    slot_stamp [NUM_SLOTS];
   bit [AGE_W-1:0]    frame_stamp;
   bit [CFG_W-1:0]    first_slot_q = RESET_FIRST_SLOT;
   bit [CFG_W-1:0]    last_slot_q = RESET_LAST_SLOT;

   bit [COLOUR_W-1:0] colour_pool [24];
   int                errors;
   bit                calm;
   bit                req_fired;
   int                gap_left;
   int                stall_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic slot_grant_type allocate_slot(input logic [COLOUR_W-1:0] colour);
      slot_grant_type grant;
      int             lo;
      int             hi;
      int             s;
      int             k;
      int             best_age;
      bit             hit;
      bit             found;
      lo = (first_slot_q < SLOT_MIN) ? int'(SLOT_MIN) : int'(first_slot_q);
      hi = (last_slot_q < SLOT_MIN) ? int'(SLOT_MIN) : int'(last_slot_q);
      if (hi < lo) hi = lo;
      s = int'(colour_map[colour]);
      hit = s >= lo && s <= hi && slot_live[s] && slot_colour[s] == colour;
      grant.loaded = !hit;
      if (!hit) begin
         s = lo;
         found = 1'b0;
         best_age = 'hffff;
         for (k = lo; k <= hi && !found; k++) begin
            if (!slot_live[k]) begin
               s = k;
               found = 1'b1;
            end else if (slot_stamp[k] != frame_stamp && int'(slot_stamp[k]) <= best_age) begin
               best_age = int'(slot_stamp[k]);
               s = k;
            end
         end
         if (slot_live[s]) colour_map[slot_colour[s]] = '0;
         slot_live[s] = 1'b1;
         slot_colour[s] = colour;
         colour_map[colour] = SLOT_W'(s);
      end
      slot_stamp[s] = frame_stamp;
      grant.slot = OUT_SLOT_W'(s);
      grant.red = {colour[14:10], colour[14:12]};
      grant.green = {colour[9:5], colour[9:7]};
      grant.blue = {colour[4:0], colour[4:2]};
      return grant;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      slot_grant_type want;
      req_fired <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_grants.size() == 0) begin
            $error("unexpected result item: slot %0d", rsp_bus.slot);
            errors++;
         end else begin
            want = due_grants.pop_front();
            check_field("slot", 16'(want.slot), 16'(rsp_bus.slot));
            check_field("loaded", 16'(want.loaded), 16'(rsp_bus.loaded));
            check_field("red", 16'(want.red), 16'(rsp_bus.red));
            check_field("green", 16'(want.green), 16'(rsp_bus.green));
            check_field("blue", 16'(want.blue), 16'(rsp_bus.blue));
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         if (req_bus.kind == KIND_FRAME) frame_stamp++;
         else due_grants.push_back(allocate_slot(req_bus.color));
      end
   end

   always @(negedge clock) begin : request_driver
      palette_req_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (colour_items.size() > 0) begin
            item = colour_items.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.kind <= item.kind;
            req_bus.color <= item.color;
            if (!calm && $urandom_range(0, 7) == 0) gap_left = int'($urandom_range(1, 14));
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : grant_sink
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!calm && $urandom_range(0, 11) == 0) stall_left = int'($urandom_range(1, 14));
      end
   end

   task automatic queue_colour(input logic [COLOUR_W-1:0] c);
      palette_req_type item;
      item.kind = KIND_COLOUR;
      item.color = c;
      colour_items.push_back(item);
   endtask

   task automatic queue_frames(input int n);
      palette_req_type item;
      repeat (n) begin
         item.kind = KIND_FRAME;
         item.color = COLOUR_W'($urandom);
         colour_items.push_back(item);
      end
   endtask

   // mostly colours from a small working set so that hits and evictions both occur
   task automatic queue_mix(input int n, input int pool_n);
      int roll;
      repeat (5) colour_pool[$urandom_range(0, 23)] = COLOUR_W'($urandom);
      repeat (n) begin
         roll = int'($urandom_range(0, 99));
         if (roll < 10) queue_frames(1);
         else if (roll < 75) queue_colour(colour_pool[$urandom_range(0, pool_n - 1)]);
         else queue_colour(COLOUR_W'($urandom));
      end
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while ((colour_items.size() != 0 || req_bus.valid || due_grants.size() != 0)
                 && waited < 3_000_000);
      if (waited >= 3_000_000) begin
         $error("results still outstanding after %0d cycles", waited);
         errors++;
      end
      repeat (5) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_FIRST_SLOT) first_slot_q = data;
      else last_slot_q = data;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_range(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
      settle();
      write_csr(CSR_FIRST_SLOT, lo);
      write_csr(CSR_LAST_SLOT, hi);
   endtask

   initial begin : stimulus
      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_FIRST_SLOT;
      csr_bus.data = '0;
      foreach (colour_pool[i]) colour_pool[i] = COLOUR_W'($urandom);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_colour(15'h0000);
      queue_colour(15'h0000);
      queue_colour(15'h7fff);
      queue_colour(15'h7c00);
      queue_colour(15'h03e0);
      queue_colour(15'h001f);
      queue_colour(15'h4210);
      queue_colour(15'h5555);
      queue_colour(15'h2aaa);
      queue_frames(1);
      queue_colour(15'h0000);
      queue_colour(15'h7fff);
      queue_frames(2);
      queue_colour(15'h2aaa);
      queue_mix(120, 16);

      set_range(8'd10, 8'd17);
      queue_mix(150, 14);
      set_range(8'd0, 8'd3);
      queue_mix(80, 8);
      set_range(8'd200, 8'd100);
      queue_mix(50, 4);
      set_range(8'd250, 8'd255);
      queue_mix(100, 10);
      set_range(8'd1, 8'd255);
      queue_mix(60, 24);

      // fill a small range, age it, then overrun it within one frame
      set_range(8'd20, 8'd23);
      repeat (4) queue_colour(COLOUR_W'($urandom));
      queue_frames(3);
      repeat (5) queue_colour(COLOUR_W'($urandom));
      queue_frames(1);
      repeat (2) queue_colour(COLOUR_W'($urandom));
      queue_mix(60, 6);

      set_range(8'd0, 8'd0);
      queue_mix(40, 4);

      set_range(8'd3, 8'd20);
      calm = 1'b1;
      queue_mix(160, 12);

      settle();
      repeat (300) @(posedge clock);
      if (due_grants.size() != 0) begin
         $error("%0d expected result items never arrived", due_grants.size());
         errors++;
      end
      if (errors == 0) $display("lru_palette_slot_allocator_core test passed");
      else $display("lru_palette_slot_allocator_core test failed");
      $finish;
   end

   initial begin : watchdog
      #40ms;
      $display("lru_palette_slot_allocator_core test failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lpsa_pkg.sv
rtl/lpsa_if.sv
rtl/lru_palette_slot_allocator_core.sv
dv/testbench.sv
